>>> design/irlc_pkg.sv
// ----------------------------------------------------------------------------
// irlc_pkg
// Shared types and constants for the infrared leader classifier.
// ----------------------------------------------------------------------------
package irlc_pkg;

  // field widths
  localparam int DurW   = 16;
  localparam int ClassW = 4;
  localparam int HzW    = 16;
  localparam int CountW = 8;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  // register map
  localparam logic [AddrW-1:0] AddrTrim = AddrW'(0);

  // defaults
  localparam int                MaxEntriesDefault = 256;
  localparam logic [DurW-1:0]   TrimReset         = DurW'(20000);

  // carrier frequencies
  localparam logic [HzW-1:0] Hz36k = HzW'(36000);
  localparam logic [HzW-1:0] Hz37k = HzW'(37000);
  localparam logic [HzW-1:0] Hz38k = HzW'(38000);
  localparam logic [HzW-1:0] Hz40k = HzW'(40000);
  localparam logic [HzW-1:0] Hz56k = HzW'(56000);

  // frame length splits
  localparam logic [CountW-1:0] MinFrame      = CountW'(2);
  localparam logic [CountW-1:0] NecLongSplit  = CountW'(70);
  localparam logic [CountW-1:0] Sirc15Split   = CountW'(27);
  localparam logic [CountW-1:0] Sirc20Split   = CountW'(33);

  typedef enum logic [ClassW-1:0] {
    ClsUnknown  = 4'd0,
    Cls9msLead  = 4'd1,
    ClsNecShort = 4'd2,
    ClsNecLong  = 4'd3,
    Cls45Pair   = 4'd4,
    Cls34Lead   = 4'd5,
    ClsSirc12   = 4'd6,
    ClsSirc15   = 4'd7,
    ClsSirc20   = 4'd8,
    ClsRc6      = 4'd9,
    Cls4msPair  = 4'd10,
    ClsRc5      = 4'd11
  } protocol_class_e;

  // leader summary handed to the classifier
  typedef struct packed {
    logic [DurW-1:0]   first_mark;
    logic [DurW-1:0]   first_space;
    logic [CountW-1:0] kept_count;
  } leader_t;

  // classifier verdict
  typedef struct packed {
    protocol_class_e  cls;
    logic [HzW-1:0]   carrier_hz;
  } verdict_t;

endpackage

>>> design/irlc_classify.sv
// ----------------------------------------------------------------------------
// irlc_classify
// Picks the protocol class and carrier from the leader mark/space pair and the kept count.
// ----------------------------------------------------------------------------
module irlc_classify import irlc_pkg::*; (
  input  leader_t  leader_i,
  output verdict_t verdict_o
);

  // open interval test
  function automatic logic in_window(logic [DurW-1:0] v, int lo, int hi);
    in_window = (v > DurW'(lo)) && (v < DurW'(hi));
  endfunction

  logic [DurW-1:0]   m;
  logic [DurW-1:0]   s;
  logic [CountW-1:0] n;

  assign m = leader_i.first_mark;
  assign s = leader_i.first_space;
  assign n = leader_i.kept_count;

  // windows tested in priority order
  always_comb begin
    verdict_o.cls        = ClsUnknown;
    verdict_o.carrier_hz = Hz38k;
    if (n >= MinFrame) begin
      if (in_window(m, 7800, 8700) && in_window(s, 3800, 4600)) begin
        verdict_o.cls        = Cls9msLead;
        verdict_o.carrier_hz = Hz40k;
      end else if (in_window(m, 8700, 10000) && in_window(s, 4000, 5000)) begin
        verdict_o.cls        = (n < NecLongSplit) ? ClsNecShort : ClsNecLong;
        verdict_o.carrier_hz = Hz38k;
      end else if (in_window(m, 4000, 5000) && in_window(s, 4000, 5000)) begin
        verdict_o.cls        = Cls45Pair;
        verdict_o.carrier_hz = Hz38k;
      end else if (in_window(m, 3100, 3800) && in_window(s, 1550, 1900)) begin
        verdict_o.cls        = Cls34Lead;
        verdict_o.carrier_hz = Hz37k;
      end else if (in_window(m, 2000, 2800) && in_window(s, 500, 700)) begin
        if (n < Sirc15Split) begin
          verdict_o.cls = ClsSirc12;
        end else if (n < Sirc20Split) begin
          verdict_o.cls = ClsSirc15;
        end else begin
          verdict_o.cls = ClsSirc20;
        end
        verdict_o.carrier_hz = Hz40k;
      end else if (in_window(m, 2400, 2900) && in_window(s, 800, 1000)) begin
        verdict_o.cls        = ClsRc6;
        verdict_o.carrier_hz = Hz36k;
      end else if (in_window(m, 3500, 4500) && in_window(s, 3500, 4500)) begin
        verdict_o.cls        = Cls4msPair;
        verdict_o.carrier_hz = Hz56k;
      end else if (in_window(m, 700, 1100) && in_window(s, 700, 1100)) begin
        verdict_o.cls        = ClsRc5;
        verdict_o.carrier_hz = Hz36k;
      end
    end
  end

endmodule

>>> design/ir_protocol_leader_classifier_top.sv
// ----------------------------------------------------------------------------
// ir_protocol_leader_classifier_top
// Tracks the leader of a captured infrared pulse train and classifies it.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, duration_us_i,    | request in
//          | is_last_i                                 |
//  out     | out_valid_o, out_stall_i, protocol_class_o,| result out
//          | carrier_hz_o, frame_length_o              |
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | register port
//          | prdata, pready                            |
//
// One request per cycle is taken unless in_stall_o is high; the result for the
// request marked is_last passes the input register, then the result register.
// The input register holds a last request while the result register is full
// and stalled; in_stall_o then holds off the next request. Any other request
// leaves the input register at the next edge.
// Reset clears the frame state, the valid flags and sets the trim threshold
// to its default; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ir_protocol_leader_classifier_top import irlc_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input request
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DurW-1:0]       duration_us_i,
  input  logic                  is_last_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ClassW-1:0]     protocol_class_o,
  output logic [HzW-1:0]        carrier_hz_o,
  output logic [CountW-1:0]     frame_length_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam int KeepLimitInt = ((MAX_ENTRIES - 1) > 255) ? 255 : (MAX_ENTRIES - 1);
  localparam logic [CountW-1:0] KeepLimit = CountW'(KeepLimitInt);

  // register port
  logic [DurW-1:0] trim_q;
  logic            trim_sel;

  assign pready   = 1'b1;
  assign trim_sel = (paddr[AddrW-1:2] == AddrTrim[AddrW-1:2]);
  assign prdata   = trim_sel ? DataW'(trim_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= TrimReset;
    end else if (psel && penable && pwrite && trim_sel) begin
      trim_q <= pwdata[DurW-1:0];
    end
  end

  // input register
  logic            s1_valid_q;
  logic [DurW-1:0] s1_dur_q;
  logic            s1_last_q;
  logic            advance;

  assign advance    = !s1_valid_q || !s1_last_q || !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      s1_dur_q  <= duration_us_i;
      s1_last_q <= is_last_i;
    end
  end

  // frame state
  logic [CountW-1:0] kept_q, kept_d;
  logic              trimmed_q, trimmed_d;
  logic [DurW-1:0]   mark_q, mark_d;
  logic [DurW-1:0]   space_q, space_d;
  logic              step;

  assign step = s1_valid_q && advance;

  always_comb begin
    kept_d    = kept_q;
    trimmed_d = trimmed_q;
    mark_d    = mark_q;
    space_d   = space_q;
    if (step) begin
      if (s1_last_q) begin
        kept_d    = '0;
        trimmed_d = 1'b0;
        mark_d    = '0;
        space_d   = '0;
      end else if (!trimmed_q && (kept_q < KeepLimit)) begin
        // an odd-position space over threshold ends the first frame
        if (kept_q[0] && (s1_dur_q > trim_q)) begin
          trimmed_d = 1'b1;
        end else begin
          if (kept_q == CountW'(0)) begin
            mark_d = s1_dur_q;
          end else if (kept_q == CountW'(1)) begin
            space_d = s1_dur_q;
          end
          kept_d = kept_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q    <= '0;
      trimmed_q <= 1'b0;
      mark_q    <= '0;
      space_q   <= '0;
    end else begin
      kept_q    <= kept_d;
      trimmed_q <= trimmed_d;
      mark_q    <= mark_d;
      space_q   <= space_d;
    end
  end

  // classification
  leader_t  leader;
  verdict_t verdict;

  assign leader.first_mark  = mark_q;
  assign leader.first_space = space_q;
  assign leader.kept_count  = kept_q;

  irlc_classify u_classify (
    .leader_i  (leader),
    .verdict_o (verdict)
  );

  // result register
  logic              out_valid_q, out_valid_d;
  logic              load;
  logic [ClassW-1:0] cls_q;
  logic [HzW-1:0]    hz_q;
  logic [CountW-1:0] len_q;

  assign load        = step && s1_last_q;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q <= verdict.cls;
      hz_q  <= verdict.carrier_hz;
      len_q <= kept_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign protocol_class_o = cls_q;
  assign carrier_hz_o     = hz_q;
  assign frame_length_o   = len_q;

endmodule
